// File: rtl/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Types and constants shared by the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

   localparam int MAX_TASKS = 64;
   localparam int SLOT_W    = $clog2(MAX_TASKS);
   localparam int COUNT_W   = $clog2(MAX_TASKS + 1);

   localparam logic [15:0] TIME_MAX = 16'hFFFF;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] task_id;
      logic [15:0] arrival_time;
      logic [15:0] burst_length;
   } req_type;

   typedef struct packed {
      logic [15:0] tick_time;
      logic        idle;
      logic [15:0] running_id;
      logic        switched;
      logic        finished;
      logic [15:0] finish_time;
      logic [15:0] turnaround;
      logic [15:0] waiting;
      logic [15:0] response;
      logic        all_done;
      logic        load_rejected;
   } rsp_type;

   // one task table entry, kept in a single memory word
   typedef struct packed {
      logic [15:0] task_id;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [15:0] remaining;
      logic [15:0] first_start;
      logic        started;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_pending;
   } status_type;

endpackage

// File: rtl/srtf_tick_scheduler_unit.sv
// ----------------------------------------------------------------------------
// srtf_tick_scheduler_unit
// Preemptive shortest-remaining-time-first scheduler over a 64-entry table.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_stall/req_data: clear, load one task, or
// run one time tick. Every request transfer produces exactly one result on
// rsp_valid/rsp_stall/rsp_data, in order.
// Clear, load and the unused opcode go from the idle state straight to the
// finish state. A tick first scans the loaded slots through the table
// memory's single read port, one slot per cycle, in the scan state.
// From the finish state the result is committed into the output register.
// While a result waits under rsp_stall, the next request is still taken and
// worked on; it holds in its final step until the output register frees.
// Reset (synchronous, active high) empties the table, zeroes the time,
// forgets the last served slot and drops any pending result. The table
// memory itself is not cleared: only slots below the task count are read.
// ----------------------------------------------------------------------------
module srtf_tick_scheduler_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  srtf_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output srtf_pkg::rsp_type   rsp_data
);

   srtf_pkg::cmd_type    cmd;
   srtf_pkg::status_type status;
   srtf_pkg::rsp_type    result;
   logic                 ready;
   logic                 out_free;

   logic                 rsp_valid_ff;
   srtf_pkg::rsp_type    rsp_data_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   srtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .out_free   (out_free),
      .status     (status),
      .ready      (ready),
      .cmd        (cmd)
   );

   srtf_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .result   (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= result;
      end
   end

endmodule

// File: rtl/srtf_ctrl.sv
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer: takes a request, runs the table scan for ticks, then commits.
// ----------------------------------------------------------------------------
module srtf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_opcode,
   input  logic                   out_free,
   input  srtf_pkg::status_type   status,
   output logic                   ready,
   output srtf_pkg::cmd_type      cmd
);

   srtf_pkg::state_type state_ff;
   srtf_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srtf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ready         = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         srtf_pkg::ST_IDLE: begin
            ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_opcode == srtf_pkg::OP_TICK) begin
                  state_in = srtf_pkg::ST_SCAN;
               end else begin
                  state_in = srtf_pkg::ST_FINISH;
               end
            end
         end
         srtf_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (!status.scan_pending) begin
               state_in = srtf_pkg::ST_FINISH;
            end
         end
         srtf_pkg::ST_FINISH: begin
            // hold until the output register can take the result
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = srtf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srtf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/srtf_dpath.sv
// ----------------------------------------------------------------------------
// srtf_dpath
// Task table memory, time and count registers, minimum scan and result math.
// ----------------------------------------------------------------------------
module srtf_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  srtf_pkg::req_type      req_data,
   input  srtf_pkg::cmd_type      cmd,
   output srtf_pkg::status_type   status,
   output srtf_pkg::rsp_type      result
);

   localparam int SLOT_W  = srtf_pkg::SLOT_W;
   localparam int COUNT_W = srtf_pkg::COUNT_W;

   srtf_pkg::entry_type mem [srtf_pkg::MAX_TASKS];

   srtf_pkg::req_type   req_ff;
   logic [COUNT_W-1:0]  task_count_ff, task_count_in;
   logic [COUNT_W-1:0]  done_count_ff, done_count_in;
   logic [15:0]         time_ff, time_in;
   logic                last_valid_ff, last_valid_in;
   logic [SLOT_W-1:0]   last_slot_ff, last_slot_in;

   logic [COUNT_W-1:0]  scan_addr_ff;
   logic                rd_valid_ff;
   srtf_pkg::entry_type rd_data_ff;
   logic [SLOT_W-1:0]   rd_slot_ff;
   logic                found_ff;
   srtf_pkg::entry_type best_ff;
   logic [SLOT_W-1:0]   best_slot_ff;

   logic                issue;
   logic                better;

   logic                mem_we;
   logic [SLOT_W-1:0]   mem_waddr;
   srtf_pkg::entry_type mem_wdata;

   logic [15:0]         fin;
   logic [15:0]         tat;
   logic [15:0]         fs_used;
   logic                load_ok;

   assign issue  = cmd.scan_step && (scan_addr_ff < task_count_ff);
   assign better = rd_valid_ff && (rd_data_ff.arrival <= time_ff)
                   && (rd_data_ff.remaining != 16'd0)
                   && (!found_ff || (rd_data_ff.remaining < best_ff.remaining));

   assign status.scan_pending = (scan_addr_ff < task_count_ff) || rd_valid_ff;

   // table memory: one read port for the scan, one write port at commit
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (issue) begin
         rd_data_ff <= mem[scan_addr_ff[SLOT_W-1:0]];
         rd_slot_ff <= scan_addr_ff[SLOT_W-1:0];
      end
   end

   // scan control and running minimum
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
      end else if (cmd.capture) begin
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (issue) begin
            scan_addr_ff <= scan_addr_ff + COUNT_W'(1);
         end
         rd_valid_ff <= issue;
         if (better) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (better) begin
         best_ff      <= rd_data_ff;
         best_slot_ff <= rd_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
         done_count_ff <= '0;
         time_ff       <= '0;
         last_valid_ff <= 1'b0;
         last_slot_ff  <= '0;
      end else if (cmd.commit) begin
         task_count_ff <= task_count_in;
         done_count_ff <= done_count_in;
         time_ff       <= time_in;
         last_valid_ff <= last_valid_in;
         last_slot_ff  <= last_slot_in;
      end
   end

   assign fin     = (time_ff == srtf_pkg::TIME_MAX) ? srtf_pkg::TIME_MAX : time_ff + 16'd1;
   assign tat     = fin - best_ff.arrival;
   assign fs_used = best_ff.started ? best_ff.first_start : time_ff;
   assign load_ok = (task_count_ff != COUNT_W'(srtf_pkg::MAX_TASKS))
                    && (req_ff.burst_length != 16'd0);

   always_comb begin
      task_count_in = task_count_ff;
      done_count_in = done_count_ff;
      time_in       = time_ff;
      last_valid_in = last_valid_ff;
      last_slot_in  = last_slot_ff;
      mem_we        = 1'b0;
      mem_waddr     = best_slot_ff;
      mem_wdata     = best_ff;
      result           = '0;
      result.tick_time = time_ff;
      unique case (req_ff.opcode)
         srtf_pkg::OP_CLEAR: begin
            task_count_in = '0;
            done_count_in = '0;
            time_in       = '0;
            last_valid_in = 1'b0;
            last_slot_in  = '0;
         end
         srtf_pkg::OP_LOAD: begin
            if (load_ok) begin
               mem_we                = cmd.commit;
               mem_waddr             = task_count_ff[SLOT_W-1:0];
               mem_wdata.task_id     = req_ff.task_id;
               mem_wdata.arrival     = req_ff.arrival_time;
               mem_wdata.burst       = req_ff.burst_length;
               mem_wdata.remaining   = req_ff.burst_length;
               mem_wdata.first_start = '0;
               mem_wdata.started     = 1'b0;
               task_count_in         = task_count_ff + COUNT_W'(1);
            end else begin
               result.load_rejected = 1'b1;
            end
         end
         srtf_pkg::OP_TICK: begin
            if (!found_ff) begin
               result.idle = 1'b1;
            end else begin
               result.running_id     = best_ff.task_id;
               result.switched       = !last_valid_ff || (last_slot_ff != best_slot_ff);
               mem_we                = cmd.commit;
               mem_wdata.remaining   = best_ff.remaining - 16'd1;
               mem_wdata.first_start = fs_used;
               mem_wdata.started     = 1'b1;
               last_valid_in         = 1'b1;
               last_slot_in          = best_slot_ff;
               if (best_ff.remaining == 16'd1) begin
                  result.finished    = 1'b1;
                  result.finish_time = fin;
                  result.turnaround  = tat;
                  result.waiting     = (tat >= best_ff.burst) ? tat - best_ff.burst : 16'd0;
                  result.response    = fs_used - best_ff.arrival;
                  done_count_in      = done_count_ff + COUNT_W'(1);
               end
            end
            if (time_ff != srtf_pkg::TIME_MAX) begin
               time_in = time_ff + 16'd1;
            end
         end
         default: begin
            // unused opcode: no state change
         end
      endcase
      result.all_done = (done_count_in == task_count_in);
   end

endmodule
